/* sv/fsds_pkg.sv */
// Shared constants, codes and types of the Fibonacci series / dedup set block.
package fsds_pkg;

    localparam int SET_DEPTH   = 256;
    localparam int MAX_TERMS   = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam int REQ_TYPE_W   = 2;
    localparam int TERM_W       = 31;
    localparam int COUNT_W      = 7;
    localparam int READ_INDEX_W = 8;
    localparam int VALUE_W      = 64;
    localparam int POS_W        = 6;
    localparam int SET_SIZE_W   = 9;

    localparam int SET_AW    = $clog2(SET_DEPTH);
    localparam int FILL_W    = SET_AW + 1;
    localparam int IDX_CMP_W = (FILL_W > READ_INDEX_W) ? FILL_W : READ_INDEX_W;
    localparam int QAW       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = QAW + 1;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_TERMS);

    localparam logic [REQ_TYPE_W-1:0] REQ_GEN   = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0]   req_type;
        logic [TERM_W-1:0]       first_term;
        logic [TERM_W-1:0]       second_term;
        logic [COUNT_W-1:0]      term_count;
        logic [READ_INDEX_W-1:0] read_index;
    } t_req;

    typedef struct packed {
        logic [VALUE_W-1:0]    value_out;
        logic [POS_W-1:0]      term_position;
        logic                  is_new;
        logic                  dropped_full;
        logic                  saturated;
        logic                  entry_valid;
        logic [SET_SIZE_W-1:0] set_size;
        logic                  bad_request;
        logic                  is_last;
    } t_res;

    typedef enum logic [1:0] {
        CMD_GEN,
        CMD_READ,
        CMD_CLEAR,
        CMD_BAD
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind               kind;
        logic [TERM_W-1:0]       first_term;
        logic [TERM_W-1:0]       second_term;
        logic [COUNT_W-1:0]      count;
        logic [READ_INDEX_W-1:0] index;
    } t_cmd;

    // front -> queue
    typedef struct packed {
        logic vld;
        t_cmd cmd;
    } t_push;

    // queue -> back
    typedef struct packed {
        logic vld;
        t_cmd cmd;
    } t_qhead;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

/* sv/fsds_if.sv */
// Request and result channel interfaces.
interface fsds_req_if;
    import fsds_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fsds_res_if;
    import fsds_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/fsds_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fsds_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/fsds_front.sv */
// Request intake: classifies requests and pushes commands into the queue.
module fsds_front (
    fsds_req_if.sink         i_req,
    input  fsds_pkg::t_qstat i_qstat,
    output fsds_pkg::t_push  o_push
);
    import fsds_pkg::*;

    logic      known;
    t_cmd_kind kind;
    logic      bad;

    assign bad = (i_req.data.second_term <= i_req.data.first_term)
              || (i_req.data.term_count == '0);

    always_comb begin
        known = 1'b1;
        kind  = CMD_GEN;
        unique case (i_req.data.req_type)
            REQ_GEN:   kind = bad ? CMD_BAD : CMD_GEN;
            REQ_READ:  kind = CMD_READ;
            REQ_CLEAR: kind = CMD_CLEAR;
            default:   known = 1'b0;   // unknown type: taken and dropped
        endcase
    end

    assign i_req.ready = !i_qstat.full;

    always_comb begin
        o_push.vld             = i_req.valid && !i_qstat.full && known;
        o_push.cmd.kind        = kind;
        o_push.cmd.first_term  = i_req.data.first_term;
        o_push.cmd.second_term = i_req.data.second_term;
        o_push.cmd.count       = (i_req.data.term_count > MAX_COUNT) ? MAX_COUNT
                                                                    : i_req.data.term_count;
        o_push.cmd.index       = i_req.data.read_index;
    end
endmodule

/* sv/fsds_queue.sv */
// Short command queue between the intake and the execution engine.
module fsds_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fsds_pkg::t_push  i_push,
    input  logic             i_pop,
    output fsds_pkg::t_qhead o_head,
    output fsds_pkg::t_qstat o_qstat
);
    import fsds_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QAW-1:0]    r_wptr;
    logic [QAW-1:0]    r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_qstat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign do_push = i_push.vld && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;

    assign o_head.vld = !o_qstat.empty;
    assign o_head.cmd = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!do_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.cmd;
        end
    end
endmodule

/* sv/fsds_back.sv */
// Execution engine: term generation, set search and insert, reads, clears.
module fsds_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fsds_pkg::t_qhead i_head,
    output logic             o_pop,
    fsds_res_if.source       o_res
);
    import fsds_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_TERM   = 6'b000010,
        ST_SEARCH = 6'b000100,
        ST_RDWAIT = 6'b001000,
        ST_EMIT   = 6'b010000,
        ST_SPARE  = 6'b100000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  r_idx;
    logic               r_pend;
    logic               r_out_vld;
    t_res               r_out;

    logic [VALUE_W-1:0] r_prev2;
    logic [VALUE_W-1:0] r_prev1;
    logic [VALUE_W-1:0] r_term;
    logic [POS_W-1:0]   r_pos;
    logic [COUNT_W-1:0] r_cnt;
    logic               r_rd_ok;
    logic               r_new;
    logic               r_drop;
    logic               r_sat;
    logic               r_valid;
    logic               r_bad;
    logic               r_last;

    logic [VALUE_W:0]   sum;
    logic               issue;
    logic               hit;
    logic               set_full;
    logic               miss_done;
    logic               load;
    logic               rd_ok;
    logic               ram_we;
    logic               ram_re;
    logic [SET_AW-1:0]  ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    assign sum       = {1'b0, r_prev2} + {1'b0, r_prev1};
    assign issue     = (r_idx < r_fill);
    assign hit       = r_pend && (ram_rdata == r_term);
    assign set_full  = (r_fill == FILL_W'(SET_DEPTH));
    assign miss_done = (r_state == ST_SEARCH) && !hit && !issue && !r_pend;
    assign load      = (r_state == ST_EMIT) && (!r_out_vld || o_res.ready);
    assign rd_ok     = IDX_CMP_W'(i_head.cmd.index) < IDX_CMP_W'(r_fill);
    assign o_pop     = (r_state == ST_IDLE) && i_head.vld;

    // one read port serves both the dedup search and set reads
    assign ram_re    = ((r_state == ST_SEARCH) && issue)
                    || (o_pop && (i_head.cmd.kind == CMD_READ));
    assign ram_raddr = (r_state == ST_SEARCH) ? r_idx[SET_AW-1:0]
                                              : SET_AW'(i_head.cmd.index);
    assign ram_we    = miss_done && !set_full;

    fsds_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (SET_DEPTH)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[SET_AW-1:0]),
        .i_wdata (r_term),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.vld) begin
                    unique case (i_head.cmd.kind)
                        CMD_GEN:   n_state = ST_TERM;
                        CMD_READ:  n_state = ST_RDWAIT;
                        CMD_CLEAR: n_state = ST_EMIT;
                        CMD_BAD:   n_state = ST_EMIT;
                    endcase
                end
            end
            ST_TERM:   n_state = ST_SEARCH;
            ST_SEARCH: begin
                if (hit || miss_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_RDWAIT: n_state = ST_EMIT;
            ST_EMIT: begin
                if (load) begin
                    n_state = r_last ? ST_IDLE : ST_TERM;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop && (i_head.cmd.kind == CMD_CLEAR)) begin
                r_fill <= '0;
            end else if (ram_we) begin
                r_fill <= r_fill + 1'b1;
            end
            if (r_state == ST_TERM) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
            end else if (r_state == ST_SEARCH) begin
                r_pend <= issue;
                if (issue) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_prev2 <= VALUE_W'(i_head.cmd.first_term);
            r_prev1 <= VALUE_W'(i_head.cmd.second_term);
            r_pos   <= '0;
            r_cnt   <= i_head.cmd.count;
            r_rd_ok <= rd_ok;
            r_term  <= '0;
            r_new   <= 1'b0;
            r_drop  <= 1'b0;
            r_sat   <= 1'b0;
            r_valid <= 1'b0;
            r_bad   <= (i_head.cmd.kind == CMD_BAD);
            r_last  <= 1'b1;
        end
        if (r_state == ST_TERM) begin
            r_new  <= 1'b0;
            r_drop <= 1'b0;
            r_last <= ({1'b0, r_pos} + 1'b1) == r_cnt;
            if (r_pos == POS_W'(0)) begin
                r_term <= r_prev2;
                r_sat  <= 1'b0;
            end else if (r_pos == POS_W'(1)) begin
                r_term <= r_prev1;
                r_sat  <= 1'b0;
            end else begin
                // a carry out saturates; later sums keep carrying
                r_term  <= sum[VALUE_W] ? '1 : sum[VALUE_W-1:0];
                r_sat   <= sum[VALUE_W];
                r_prev2 <= r_prev1;
                r_prev1 <= sum[VALUE_W] ? '1 : sum[VALUE_W-1:0];
            end
        end
        if (miss_done) begin
            r_new  <= !set_full;
            r_drop <= set_full;
        end
        if (r_state == ST_RDWAIT) begin
            r_term  <= r_rd_ok ? ram_rdata : '0;
            r_valid <= r_rd_ok;
        end
        if (load && !r_last) begin
            r_pos <= r_pos + 1'b1;
        end
        if (load) begin
            r_out.value_out     <= r_term;
            r_out.term_position <= r_pos;
            r_out.is_new        <= r_new;
            r_out.dropped_full  <= r_drop;
            r_out.saturated     <= r_sat;
            r_out.entry_valid   <= r_valid;
            r_out.set_size      <= SET_SIZE_W'(r_fill);
            r_out.bad_request   <= r_bad;
            r_out.is_last       <= r_last;
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;
endmodule

/* sv/fibonacci_series_dedup_set.sv */
// Top level of the Fibonacci series generator with insertion-ordered dedup set.
// Requests are taken into a two-entry command queue and carried out one at a
// time by an engine that keeps the set in a single-port-read RAM. A generate
// request emits one result per term. Each term is formed, then searched for
// with one RAM read per stored entry; the search closes after the last read
// data is compared or at a match, and then the result is emitted. The linear
// search through the RAM read port is the slow part of the engine. The set
// needs no clearing after reset: only entries below the fill count are used.
module fibonacci_series_dedup_set (
    input logic        i_clk,
    input logic        i_rst_n,
    fsds_req_if.sink   i_req,
    fsds_res_if.source o_res
);
    import fsds_pkg::*;

    t_push  push;
    t_qhead head;
    t_qstat qstat;
    logic   pop;

    fsds_front u_front (
        .i_req   (i_req),
        .i_qstat (qstat),
        .o_push  (push)
    );

    fsds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    fsds_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_res   (o_res)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.vld |-> !qstat.full)
        else $error("command pushed into a full queue");

    a_new_or_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.data.is_new && o_res.data.dropped_full))
        else $error("term both inserted and dropped");

    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.bad_request) |-> o_res.data.is_last)
        else $error("rejected request result not marked last");

    a_pop_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("engine popped an empty queue");
endmodule

/* bench/tb.sv */
// Self-checking testbench for the Fibonacci series generator with its insertion-ordered dedup set.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fsds_pkg::*;

    // req_type 3 has no meaning; the block drops it without a result
    localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [TERM_W-1:0]     TERM_MAX   = '1;
    localparam int                    PRINT_CAP  = 100;

    logic i_clk;
    logic i_rst_n;

    fsds_req_if req_bus();
    fsds_res_if res_bus();

    fibonacci_series_dedup_set uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus)
    );

    // shadow copy of the stored set
    logic [VALUE_W-1:0] shadow_set [SET_DEPTH];
    int                 shadow_fill;

    t_res pending_results [$];
    int   error_count;
    int   result_count;

    // sender / receiver pacing
    bit sink_stalls;
    bit source_gaps;
    int burst_left;
    int hold_cycles;
    bit sink_open;
    int run_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #25_000_000;
        $display("[fibonacci_series_dedup_set] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("%0t mismatch: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] got,
                               input logic [VALUE_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                      result_count, name, got, want));
    endtask

    task automatic check_result(input t_res got);
        t_res want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing pending, value %0h",
                                      result_count, got.value_out));
        end else begin
            want = pending_results.pop_front();
            check_field("value_out", got.value_out, want.value_out);
            check_field("term_position", VALUE_W'(got.term_position),
                        VALUE_W'(want.term_position));
            check_field("is_new", VALUE_W'(got.is_new), VALUE_W'(want.is_new));
            check_field("dropped_full", VALUE_W'(got.dropped_full),
                        VALUE_W'(want.dropped_full));
            check_field("saturated", VALUE_W'(got.saturated), VALUE_W'(want.saturated));
            check_field("entry_valid", VALUE_W'(got.entry_valid),
                        VALUE_W'(want.entry_valid));
            check_field("set_size", VALUE_W'(got.set_size), VALUE_W'(want.set_size));
            check_field("bad_request", VALUE_W'(got.bad_request),
                        VALUE_W'(want.bad_request));
            check_field("is_last", VALUE_W'(got.is_last), VALUE_W'(want.is_last));
        end
        result_count++;
    endtask

    // Works out the results of one accepted request and updates the shadow set.
    task automatic model_request(input t_req r);
        t_res               res;
        logic [VALUE_W-1:0] older;
        logic [VALUE_W-1:0] newer;
        logic [VALUE_W-1:0] term;
        logic [VALUE_W:0]   wide;
        int                 n;
        bit                 hit;
        bit                 sat;
        res = '0;
        case (r.req_type)
            REQ_GEN: begin
                if (r.second_term <= r.first_term || r.term_count == 0) begin
                    res.bad_request = 1'b1;
                    res.is_last     = 1'b1;
                    res.set_size    = SET_SIZE_W'(shadow_fill);
                    pending_results.push_back(res);
                end else begin
                    n     = (r.term_count > MAX_TERMS) ? MAX_TERMS : int'(r.term_count);
                    older = VALUE_W'(r.first_term);
                    newer = VALUE_W'(r.second_term);
                    for (int j = 0; j < n; j++) begin
                        sat = 1'b0;
                        if (j == 0) begin
                            term = older;
                        end else if (j == 1) begin
                            term = newer;
                        end else begin
                            wide = {1'b0, older} + {1'b0, newer};
                            if (wide[VALUE_W]) begin
                                term = '1;
                                sat  = 1'b1;
                            end else begin
                                term = wide[VALUE_W-1:0];
                            end
                            older = newer;
                            newer = term;
                        end
                        res               = '0;
                        res.value_out     = term;
                        res.term_position = POS_W'(j);
                        res.saturated     = sat;
                        res.is_last       = (j == n - 1);
                        hit = 1'b0;
                        for (int i = 0; i < shadow_fill; i++)
                            if (shadow_set[i] == term)
                                hit = 1'b1;
                        if (!hit) begin
                            if (shadow_fill >= SET_DEPTH) begin
                                res.dropped_full = 1'b1;
                            end else begin
                                shadow_set[shadow_fill] = term;
                                shadow_fill++;
                                res.is_new = 1'b1;
                            end
                        end
                        res.set_size = SET_SIZE_W'(shadow_fill);
                        pending_results.push_back(res);
                    end
                end
            end
            REQ_READ: begin
                if (r.read_index < shadow_fill) begin
                    res.value_out   = shadow_set[r.read_index];
                    res.entry_valid = 1'b1;
                end
                res.set_size = SET_SIZE_W'(shadow_fill);
                res.is_last  = 1'b1;
                pending_results.push_back(res);
            end
            REQ_CLEAR: begin
                shadow_fill = 0;
                res.is_last = 1'b1;
                pending_results.push_back(res);
            end
            default: ;
        endcase
    endtask

    // Offers one request, waits for it to be taken, then maybe pauses.
    task automatic send_req(input t_req r);
        req_bus.valid <= 1'b1;
        req_bus.data  <= r;
        do @(posedge i_clk); while (!req_bus.ready);
        model_request(r);
        if (burst_left > 0) begin
            burst_left--;
        end else if (source_gaps) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    function automatic t_req make_gen(input logic [TERM_W-1:0] t0, input logic [TERM_W-1:0] t1,
                                      input logic [COUNT_W-1:0] count);
        make_gen             = '0;
        make_gen.req_type    = REQ_GEN;
        make_gen.first_term  = t0;
        make_gen.second_term = t1;
        make_gen.term_count  = count;
    endfunction

    function automatic t_req make_read(input logic [READ_INDEX_W-1:0] idx);
        make_read            = '0;
        make_read.req_type   = REQ_READ;
        make_read.read_index = idx;
    endfunction

    function automatic t_req make_clear();
        make_clear          = '0;
        make_clear.req_type = REQ_CLEAR;
    endfunction

    // stop offering the last request, then wait for every result
    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Result side: checks every accepted result and paces ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready)
                check_result(res_bus.data);
            if (hold_cycles > 0) begin
                hold_cycles--;
                res_bus.ready <= 1'b0;
            end else if (!sink_stalls) begin
                res_bus.ready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    sink_open = !sink_open;
                    run_left  = sink_open ? $urandom_range(1, 12) : $urandom_range(1, 5);
                end
                run_left--;
                res_bus.ready <= sink_open;
            end
        end
    end

    task automatic test_directed();
        t_req r;
        sink_stalls = 1'b1;
        source_gaps = 1'b1;
        send_req(make_gen(31'd1, 31'd2, 7'd10));
        send_req(make_gen(31'd1, 31'd2, 7'd10));     // every term already stored
        send_req(make_gen(31'd5, 31'd7, 7'd1));      // only the first term
        send_req(make_gen(31'd5, 31'd9, 7'd2));
        send_req(make_gen(31'd0, 31'd1, 7'd6));      // repeats inside one series
        send_req(make_gen(31'd3, 31'd3, 7'd4));      // equal start terms
        send_req(make_gen(31'd9, 31'd4, 7'd4));      // descending start terms
        send_req(make_gen(31'd1, 31'd2, 7'd0));      // zero count
        send_req(make_gen(TERM_MAX, TERM_MAX, 7'd5));
        send_req(make_gen(TERM_MAX - 31'd1, TERM_MAX, 7'd64));   // runs into saturation
        send_req(make_gen(31'd2, 31'd3, 7'd127));    // count beyond the maximum
        send_req(make_read(8'd0));
        send_req(make_read(8'd5));
        send_req(make_read(READ_INDEX_W'(shadow_fill - 1)));
        send_req(make_read(READ_INDEX_W'(shadow_fill < SET_DEPTH - 1 ? shadow_fill : 255)));
        send_req(make_read(8'd255));
        r            = make_gen(31'd4, 31'd8, 7'd3);
        r.req_type   = REQ_UNUSED;
        r.read_index = 8'hA5;
        send_req(r);
        send_req(make_clear());
        send_req(make_read(8'd0));
        send_req(make_gen(31'd1, 31'd2, 7'd3));
        send_req(make_read(8'd2));
    endtask

    // Fills all entries, then pushes new terms that cannot be stored.
    task automatic test_set_full();
        logic [TERM_W-1:0] t0;
        int                extra;
        sink_stalls = 1'b0;
        source_gaps = 1'b0;
        send_req(make_clear());
        extra = 0;
        while (extra < 2) begin
            if (shadow_fill >= SET_DEPTH)
                extra++;
            t0 = TERM_W'($urandom_range(1, 1000));
            send_req(make_gen(t0, t0 + TERM_W'($urandom_range(1, 1000)), 7'd64));
        end
        send_req(make_read(8'd255));
        send_req(make_read(8'd0));
        send_req(make_read(READ_INDEX_W'($urandom)));
        send_req(make_gen(31'd1, 31'd2, 7'd5));
        wait_drained();
    endtask

    // Receiver stops for a long time while requests keep coming.
    task automatic test_backpressure();
        sink_stalls = 1'b1;
        source_gaps = 1'b0;
        burst_left  = 0;
        wait_drained();
        hold_cycles = 400;
        for (int k = 0; k < 10; k++) begin
            case (k % 3)
                0: send_req(make_read(READ_INDEX_W'($urandom)));
                1: send_req(make_gen(31'd10, 31'd11, COUNT_W'($urandom_range(1, 4))));
                default: send_req(make_clear());
            endcase
        end
        source_gaps = 1'b1;
        wait_drained();
    endtask

    task automatic test_random_traffic();
        t_req              r;
        int                sent;
        int                pick;
        logic [TERM_W-1:0] t0;
        sent = 0;
        while (sent < 70) begin
            sink_stalls = ((sent / 20) % 2) == 0;
            source_gaps = ((sent / 35) % 3) != 2;
            pick = $urandom_range(0, 99);
            // unused fields carry noise on purpose
            r.first_term  = TERM_W'($urandom);
            r.second_term = TERM_W'($urandom);
            r.term_count  = COUNT_W'($urandom);
            r.read_index  = READ_INDEX_W'($urandom);
            if (pick < 4) begin
                r.req_type = REQ_UNUSED;
            end else if (pick < 12) begin
                r.req_type = REQ_CLEAR;
            end else if (pick < 32) begin
                r.req_type = REQ_READ;
                if (shadow_fill > 0 && $urandom_range(0, 2) != 0)
                    r.read_index = READ_INDEX_W'($urandom_range(0, shadow_fill - 1));
            end else begin
                r.req_type = REQ_GEN;
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    t0            = TERM_W'($urandom_range(0, 2000));
                    r.first_term  = t0;
                    r.second_term = t0 + TERM_W'($urandom_range(1, 2000));
                end else if (pick < 9) begin
                    t0            = TERM_W'($urandom_range(0, 32'h7FFF_FFFE));
                    r.first_term  = t0;
                    r.second_term = TERM_W'($urandom_range(t0 + 32'd1, 32'h7FFF_FFFF));
                end
                // otherwise both start terms stay raw, often a rejected request
                pick = $urandom_range(0, 19);
                if (pick < 17)
                    r.term_count = COUNT_W'($urandom_range(1, 8));
                else if (pick < 19)
                    r.term_count = COUNT_W'($urandom_range(9, 64));
            end
            send_req(r);
            if (r.req_type != REQ_UNUSED)
                sent++;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.data  = '0;
        shadow_fill   = 0;
        error_count   = 0;
        result_count  = 0;
        sink_stalls   = 1'b0;
        source_gaps   = 1'b0;
        burst_left    = 0;
        hold_cycles   = 0;
        sink_open     = 1'b1;
        run_left      = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_set_full();
        test_backpressure();
        test_random_traffic();

        req_bus.valid <= 1'b0;
        wait_drained();
        repeat (64) @(posedge i_clk);
        if (error_count == 0)
            $display("[fibonacci_series_dedup_set] OK");
        else
            $display("[fibonacci_series_dedup_set] ERROR");
        $finish;
    end

endmodule

/* fibonacci_series_dedup_set.f */
sv/fsds_pkg.sv
sv/fsds_if.sv
sv/fsds_ram.sv
sv/fsds_front.sv
sv/fsds_queue.sv
sv/fsds_back.sv
sv/fibonacci_series_dedup_set.sv
bench/tb.sv
